[sv/smes_pkg.sv]
// Shared constants, codes and types for the sparse matrix entry store.
// Depends on nothing; smes_if and the top level refer to it by scoped names.
package smes_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int VAL_W    = 32;
  localparam int BOUND_W  = 11;
  localparam int STAT_W   = 2;
  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [BOUND_W-1:0] MAX_ROWS_B = BOUND_W'(MAX_ROWS);
  localparam logic [BOUND_W-1:0] MAX_COLS_B = BOUND_W'(MAX_COLS);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/smes_if.sv]
// Request and response channels of the sparse matrix entry store.
// Depends on smes_pkg for field widths.
interface smes_req_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [smes_pkg::ROW_W-1:0]        row;
  logic [smes_pkg::COL_W-1:0]        col;
  logic signed [smes_pkg::VAL_W-1:0] write_value;

  modport source (output valid, op, row, col, write_value, input ready);
  modport sink (input valid, op, row, col, write_value, output ready);
endinterface

interface smes_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [smes_pkg::VAL_W-1:0]  read_value;
  logic                               found;
  logic [smes_pkg::STAT_W-1:0]        status;

  modport source (output valid, read_value, found, status, input ready);
  modport sink (input valid, read_value, found, status, output ready);
endinterface

[sv/smes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module smes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sparse_matrix_entry_store.sv]
// Top level of the sparse matrix entry store: APB register port, slot scan sequencer.
// Depends on smes_pkg, smes_req_if, smes_rsp_if and smes_ram.
//
// Each word on req is one read or write at a (row, col) coordinate; each produces one
// word on rsp. The entries live in a 64-slot table held in a single RAM plus a row of
// valid flags. An in-range request scans the whole table, one RAM read per slot: the
// sequencer accepts it in S_IDLE, reads the slots in S_SCAN, makes the last compare in
// S_LAST and commits in S_DONE once the output register is free; an out-of-range
// request goes from S_IDLE straight to S_DONE. The RAM read port sets the scan length.
// req is ready only when the sequencer is idle; a finished response waits in the output
// register while the next word is taken.
// Registers: rows_in_use at 0x0, cols_in_use at 0x4, both 11 bits, reset 1024.
module sparse_matrix_entry_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smes_pkg::PADDR_W-1:0] paddr,
  input  logic [smes_pkg::PDATA_W-1:0] pwdata,
  output logic [smes_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  smes_req_if.sink                     req,
  smes_rsp_if.source                   rsp
);

  smes_pkg::state_t state, state_next;

  logic [smes_pkg::BOUND_W-1:0] rows_in_use;
  logic [smes_pkg::BOUND_W-1:0] cols_in_use;
  logic [smes_pkg::BOUND_W-1:0] row_bound;
  logic [smes_pkg::BOUND_W-1:0] col_bound;

  logic                        item_op;
  logic [smes_pkg::ROW_W-1:0]  item_row;
  logic [smes_pkg::COL_W-1:0]  item_col;
  logic [smes_pkg::VAL_W-1:0]  item_value;
  logic                        range_err;

  logic [smes_pkg::SLOT_W-1:0] scan_idx;
  logic                        chk_en;
  logic [smes_pkg::SLOT_W-1:0] chk_idx;
  logic                        hit;
  logic [smes_pkg::SLOT_W-1:0] hit_idx;
  logic [smes_pkg::VAL_W-1:0]  hit_value;
  logic                        free_ok;
  logic [smes_pkg::SLOT_W-1:0] free_idx;

  logic [smes_pkg::CAPACITY-1:0] slot_valid;

  smes_pkg::entry_t            rd_data;
  smes_pkg::entry_t            wr_data;
  logic                        ram_we;
  logic [smes_pkg::SLOT_W-1:0] ram_waddr;

  logic                        out_valid;
  logic [smes_pkg::VAL_W-1:0]  out_value;
  logic                        out_found;
  smes_pkg::status_t           out_status;

  logic                        accept;
  logic                        load;
  logic                        in_range;
  logic                        valid_set;
  logic                        valid_clr;
  logic [smes_pkg::SLOT_W-1:0] valid_idx;
  logic [smes_pkg::VAL_W-1:0]  res_value;
  logic                        res_found;
  smes_pkg::status_t           res_status;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= smes_pkg::MAX_ROWS_B;
      cols_in_use <= smes_pkg::MAX_COLS_B;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        smes_pkg::REG_ROWS: rows_in_use <= pwdata[smes_pkg::BOUND_W-1:0];
        smes_pkg::REG_COLS: cols_in_use <= pwdata[smes_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      smes_pkg::REG_ROWS: prdata = smes_pkg::PDATA_W'(rows_in_use);
      smes_pkg::REG_COLS: prdata = smes_pkg::PDATA_W'(cols_in_use);
      default:            prdata = '0;
    endcase
  end

  assign row_bound = (rows_in_use < smes_pkg::MAX_ROWS_B) ? rows_in_use : smes_pkg::MAX_ROWS_B;
  assign col_bound = (cols_in_use < smes_pkg::MAX_COLS_B) ? cols_in_use : smes_pkg::MAX_COLS_B;
  assign in_range  = (smes_pkg::BOUND_W'(req.row) < row_bound) &&
                     (smes_pkg::BOUND_W'(req.col) < col_bound);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smes_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smes_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = in_range ? smes_pkg::S_SCAN : smes_pkg::S_DONE;
        end
      end
      smes_pkg::S_SCAN: begin
        if (scan_idx == smes_pkg::SLOT_W'(smes_pkg::CAPACITY - 1)) begin
          state_next = smes_pkg::S_LAST;
        end
      end
      smes_pkg::S_LAST: state_next = smes_pkg::S_DONE;
      smes_pkg::S_DONE: begin
        if (load) begin
          state_next = smes_pkg::S_IDLE;
        end
      end
      default: state_next = smes_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    load       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    valid_idx  = hit_idx;
    res_value  = '0;
    res_found  = 1'b0;
    res_status = smes_pkg::ST_OK;
    case (state)
      smes_pkg::S_IDLE: req.ready = 1'b1;
      smes_pkg::S_DONE: begin
        load = !out_valid || rsp.ready;
        if (range_err) begin
          res_status = smes_pkg::ST_RANGE;
        end else if (item_op == smes_pkg::OP_READ) begin
          res_found = hit;
          res_value = hit ? hit_value : '0;
        end else begin
          res_found = hit;
          if (hit) begin
            ram_we    = load && (item_value != '0);
            valid_clr = load && (item_value == '0);
          end else if (item_value != '0) begin
            if (free_ok) begin
              ram_we    = load;
              ram_waddr = free_idx;
              valid_set = load;
              valid_idx = free_idx;
            end else begin
              res_status = smes_pkg::ST_FULL;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;

  // Hold the item, advance the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op    <= req.op;
      item_row   <= req.row;
      item_col   <= req.col;
      item_value <= req.write_value;
      range_err  <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      chk_en   <= 1'b0;
      chk_idx  <= '0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end else begin
      chk_en  <= (state == smes_pkg::S_SCAN);
      chk_idx <= scan_idx;
      if (accept) begin
        scan_idx <= '0;
        hit      <= 1'b0;
        free_ok  <= 1'b0;
      end else begin
        if (state == smes_pkg::S_SCAN) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (chk_en) begin
          if (slot_valid[chk_idx]) begin
            if (!hit && rd_data.row == item_row && rd_data.col == item_col) begin
              hit <= 1'b1;
            end
          end else if (!free_ok) begin
            free_ok <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_en) begin
      if (slot_valid[chk_idx]) begin
        if (!hit && rd_data.row == item_row && rd_data.col == item_col) begin
          hit_idx   <= chk_idx;
          hit_value <= rd_data.value;
        end
      end else if (!free_ok) begin
        free_idx <= chk_idx;
      end
    end
  end

  // Slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (valid_set) begin
      slot_valid[valid_idx] <= 1'b1;
    end else if (valid_clr) begin
      slot_valid[valid_idx] <= 1'b0;
    end
  end

  assign wr_data.row   = item_row;
  assign wr_data.col   = item_col;
  assign wr_data.value = item_value;

  smes_ram #(
    .WIDTH (smes_pkg::ENTRY_W),
    .DEPTH (smes_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_data),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= res_value;
      out_found  <= res_found;
      out_status <= res_status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.found      = out_found;
  assign rsp.status     = out_status;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != smes_pkg::S_IDLE)
    else $error("sequencer stayed idle after taking a word");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == smes_pkg::S_DONE)
    else $error("response raised outside the commit state");

  a_valid_only_commit: assert property (@(posedge clk) disable iff (rst)
    state != smes_pkg::S_DONE |=> $stable(slot_valid))
    else $error("slot flags changed outside the commit state");

  a_no_found_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.status != smes_pkg::ST_OK))
    else $error("found flagged on an error response");

endmodule
